/* hw/rtl/mxy_pkg.sv */
// ----------------------------------------------------------------------------
// mxy_pkg
// Shared types and constants for the XY mesh route generator.
// ----------------------------------------------------------------------------
package mxy_pkg;

  localparam int NODE_W      = 8;   // node number width
  localparam int DIM_W       = 5;   // mesh dimension register width
  localparam int MAX_DIM_DEF = 16;  // default largest mesh dimension

  // configuration register indexes
  localparam logic REG_MESH_WIDTH  = 1'b0;
  localparam logic REG_MESH_HEIGHT = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic              last;
    logic              error;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, start divider
    logic div_step;  // one restoring-division step
    logic div_last;  // final step: load coordinates
    logic emit;      // emit current node, take one hop
    logic emit_err;  // emit the single error item
  } mxy_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;   // both request nodes inside the mesh
    logic at_goal;    // current position equals target
    logic slot_free;  // output register can take an item
  } mxy_status_t;

endpackage

/* hw/rtl/mesh_xy_route_generator.sv */
// ----------------------------------------------------------------------------
// mesh_xy_route_generator
// XY dimension-order route on a row-major 2D mesh, one node per output item.
// ----------------------------------------------------------------------------
//
//   channel  direction  payload                          handshake
//   -------  ---------  -------------------------------  ----------------
//   in_      input      source_node, target_node         in_valid/in_stall
//   out_     output     node_id, last, error             out_valid/out_stall
//   cfg_     input      mesh_width (0), mesh_height (1)  cfg_we, no wait
//
// Flow: one item at a time. Accept, then an 8-step restoring divide (both
//   nodes split into column/row in parallel), then one route node leaves
//   per cycle unless out_stall holds the output register. An out-of-range
//   item yields a single error item after accept.
// Reset: rst_n is synchronous, active low; mesh returns to 4x4.
// Stalls: out_stall holds the output register; the walk pauses with it.
//   in_stall is high from accept until the last node is in the output
//   register, so the next item can enter while that node waits.
//
module mesh_xy_route_generator #(
  parameter int MAX_DIM = mxy_pkg::MAX_DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  mxy_pkg::in_item_t         in_item,
  // route node channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output mxy_pkg::out_item_t        out_item,
  // configuration
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mxy_pkg::DIM_W-1:0] cfg_data
);

  mxy_pkg::mxy_cmd_t    cmd;
  mxy_pkg::mxy_status_t sts;

  // sequencer: idle -> divide -> walk (or single error item) -> idle
  mxy_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, divider lanes, coordinate walk and output register
  mxy_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef ASSERT_OFF
  // an error item always closes its route
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.error || out_item.last))
    else $error("error item without last");

  // only one of load, div_step, emit, emit_err at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.emit, cmd.emit_err}))
    else $error("conflicting datapath commands");

  // an accepted item blocks the input for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  // a node is emitted only when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_err) |-> (!out_valid || !out_stall))
    else $error("emit into a held output register");
`endif

endmodule

/* hw/rtl/mxy_ctrl.sv */
// ----------------------------------------------------------------------------
// mxy_ctrl
// Sequencer: accept, divide, walk the route, issue datapath commands.
// ----------------------------------------------------------------------------
module mxy_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mxy_pkg::mxy_status_t sts,
  output mxy_pkg::mxy_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_ERR  = 2'd3;

  localparam int DIV_STEPS = mxy_pkg::NODE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = sts.in_range ? S_DIV : S_ERR;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.at_goal) state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.slot_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/mxy_dp.sv */
// ----------------------------------------------------------------------------
// mxy_dp
// Datapath: mesh registers, two-lane divider, position walk, output register.
// ----------------------------------------------------------------------------
module mxy_dp #(
  parameter int MAX_DIM = mxy_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [mxy_pkg::DIM_W-1:0]        cfg_data,
  input  mxy_pkg::in_item_t                in_item,
  output mxy_pkg::out_item_t               out_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  mxy_pkg::mxy_cmd_t                cmd,
  output mxy_pkg::mxy_status_t             sts
);

  localparam int NW      = mxy_pkg::NODE_W;
  localparam int DW      = mxy_pkg::DIM_W;
  localparam int COORD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // ---- configuration ----
  logic [DW-1:0] width_r, height_r;
  logic [DW-1:0] w_eff, h_eff;
  logic [2*DW-1:0] nodes;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(4);
      height_r <= DW'(4);
    end else if (cfg_we) begin
      case (cfg_index)
        mxy_pkg::REG_MESH_WIDTH:  width_r  <= cfg_data;
        mxy_pkg::REG_MESH_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = v;
    if (v == '0) r = DW'(1);
    else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
    return r;
  endfunction

  assign w_eff = clamp_dim(width_r);
  assign h_eff = clamp_dim(height_r);
  assign nodes = w_eff * h_eff;

  assign sts.in_range = ((2*DW)'(in_item.source_node) < nodes) &&
                        ((2*DW)'(in_item.target_node) < nodes);

  // ---- restoring divider, source and target lanes ----
  // dividend register shifts left and fills with quotient bits
  logic [NW-1:0] sq_r, tq_r, sq_nxt, tq_nxt;
  logic [DW-1:0] sr_r, tr_r, sr_nxt, tr_nxt;

  function automatic logic [NW+DW-1:0] div_step(input logic [NW-1:0] q,
                                                input logic [DW-1:0] rem,
                                                input logic [DW-1:0] d);
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_o;
    trial = {rem, q[NW-1]};
    ge    = (trial >= {1'b0, d});
    rem_o = ge ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
    return {q[NW-2:0], ge, rem_o};
  endfunction

  always_comb begin
    {sq_nxt, sr_nxt} = div_step(sq_r, sr_r, w_eff);
    {tq_nxt, tr_nxt} = div_step(tq_r, tr_r, w_eff);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_r <= in_item.source_node;
      tq_r <= in_item.target_node;
      sr_r <= '0;
      tr_r <= '0;
    end else if (cmd.div_step) begin
      sq_r <= sq_nxt;
      tq_r <= tq_nxt;
      sr_r <= sr_nxt;
      tr_r <= tr_nxt;
    end
  end

  // ---- position walk ----
  logic [COORD_W-1:0] col_r, row_r, gcol_r, grow_r;
  logic [COORD_W-1:0] col_nxt, row_nxt;
  logic [NW-1:0]      node_r, node_nxt;

  assign sts.at_goal = (col_r == gcol_r) && (row_r == grow_r);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    node_nxt = node_r;
    if (col_r != gcol_r) begin
      if (gcol_r > col_r) begin
        col_nxt  = col_r + 1'b1;
        node_nxt = node_r + 1'b1;
      end else begin
        col_nxt  = col_r - 1'b1;
        node_nxt = node_r - 1'b1;
      end
    end else if (row_r != grow_r) begin
      if (grow_r > row_r) begin
        row_nxt  = row_r + 1'b1;
        node_nxt = node_r + NW'(w_eff);
      end else begin
        row_nxt  = row_r - 1'b1;
        node_nxt = node_r - NW'(w_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r <= in_item.source_node;
    end else if (cmd.div_last) begin
      col_r  <= COORD_W'(sr_nxt);
      row_r  <= COORD_W'(sq_nxt);
      gcol_r <= COORD_W'(tr_nxt);
      grow_r <= COORD_W'(tq_nxt);
    end else if (cmd.emit) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      node_r <= node_nxt;
    end
  end

  // ---- output register ----
  logic               out_valid_r, out_valid_nxt;
  mxy_pkg::out_item_t out_item_r;

  assign sts.slot_free = !out_valid_r || !out_stall;
  assign out_valid_nxt = (cmd.emit || cmd.emit_err) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.node_id <= node_r;
      out_item_r.last    <= sts.at_goal;
      out_item_r.error   <= 1'b0;
    end else if (cmd.emit_err) begin
      out_item_r.node_id <= node_r;
      out_item_r.last    <= 1'b1;
      out_item_r.error   <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XY mesh route generator.
//
// A directed table is run first: corner routes, out-of-range nodes and
// register values outside 1..16 at several mesh sizes. It is followed by
// random phases, each with a fresh mesh size and 22 requests. Every
// accepted request is expanded into its expected run of route nodes by a
// local XY router, unless a table row gives the single result directly.
// Each delivered node is checked against the oldest expected one. Random
// gaps on the request side and random stalls on the node side are applied
// throughout.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case is 31 nodes per request, each held by the longest stall, over
  // about 155 requests. The limit is several times that.
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 22;
  localparam int SHOW_MAX    = 10;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  // One directed step. For ROW_CFG, src holds the register index and dst the
  // data. For ROW_REQ with fixed set, want is the single node expected.
  typedef struct packed {
    row_kind_t                  kind;
    logic [mxy_pkg::NODE_W-1:0] src;
    logic [mxy_pkg::NODE_W-1:0] dst;
    logic                       fixed;
    mxy_pkg::out_item_t         want;
  } dir_row_t;

  localparam logic [mxy_pkg::NODE_W-1:0] IDX_W =
    mxy_pkg::NODE_W'(mxy_pkg::REG_MESH_WIDTH);
  localparam logic [mxy_pkg::NODE_W-1:0] IDX_H =
    mxy_pkg::NODE_W'(mxy_pkg::REG_MESH_HEIGHT);

  localparam int DIR_ROWS = 31;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // reset size 4x4
    '{ROW_REQ, 8'd0,   8'd0,   1'b1, '{8'd0,   1'b1, 1'b0}},  // one node after reset
    '{ROW_REQ, 8'd15,  8'd15,  1'b1, '{8'd15,  1'b1, 1'b0}},  // last node, no hop
    '{ROW_REQ, 8'd0,   8'd15,  1'b0, '0},                     // corner to corner
    '{ROW_REQ, 8'd15,  8'd0,   1'b0, '0},                     // walk back
    '{ROW_REQ, 8'd5,   8'd10,  1'b0, '0},
    '{ROW_REQ, 8'd16,  8'd0,   1'b1, '{8'd16,  1'b1, 1'b1}},  // source just outside
    '{ROW_REQ, 8'd3,   8'd16,  1'b1, '{8'd3,   1'b1, 1'b1}},  // target just outside
    '{ROW_REQ, 8'd255, 8'd255, 1'b1, '{8'd255, 1'b1, 1'b1}},
    // largest mesh, 16x16
    '{ROW_CFG, IDX_W,  8'd16,  1'b0, '0},
    '{ROW_CFG, IDX_H,  8'd16,  1'b0, '0},
    '{ROW_REQ, 8'd0,   8'd255, 1'b0, '0},                     // longest route
    '{ROW_REQ, 8'd255, 8'd0,   1'b0, '0},
    '{ROW_REQ, 8'd170, 8'd85,  1'b0, '0},
    '{ROW_REQ, 8'd255, 8'd255, 1'b1, '{8'd255, 1'b1, 1'b0}},
    // zero width acts as 1, oversized height saturates: 1x16
    '{ROW_CFG, IDX_W,  8'd0,   1'b0, '0},
    '{ROW_CFG, IDX_H,  8'd31,  1'b0, '0},
    '{ROW_REQ, 8'd0,   8'd15,  1'b0, '0},                     // column only
    '{ROW_REQ, 8'd16,  8'd0,   1'b1, '{8'd16,  1'b1, 1'b1}},
    // oversized width, zero height: 16x1
    '{ROW_CFG, IDX_W,  8'd31,  1'b0, '0},
    '{ROW_CFG, IDX_H,  8'd0,   1'b0, '0},
    '{ROW_REQ, 8'd15,  8'd0,   1'b0, '0},                     // row only
    '{ROW_REQ, 8'd3,   8'd16,  1'b1, '{8'd3,   1'b1, 1'b1}},
    // single node mesh
    '{ROW_CFG, IDX_W,  8'd1,   1'b0, '0},
    '{ROW_CFG, IDX_H,  8'd1,   1'b0, '0},
    '{ROW_REQ, 8'd0,   8'd0,   1'b1, '{8'd0,   1'b1, 1'b0}},
    '{ROW_REQ, 8'd0,   8'd1,   1'b1, '{8'd0,   1'b1, 1'b1}},
    // odd width, 7x3
    '{ROW_CFG, IDX_W,  8'd7,   1'b0, '0},
    '{ROW_CFG, IDX_H,  8'd3,   1'b0, '0},
    '{ROW_REQ, 8'd20,  8'd0,   1'b0, '0},
    '{ROW_REQ, 8'd1,   8'd19,  1'b0, '0},
    '{ROW_REQ, 8'd21,  8'd0,   1'b1, '{8'd21,  1'b1, 1'b1}}
  };

  // DUT inputs are known from time zero
  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  mxy_pkg::in_item_t           in_item   = '0;
  logic                        out_stall = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [mxy_pkg::DIM_W-1:0]   cfg_data  = '0;

  logic                        in_stall;
  logic                        out_valid;
  mxy_pkg::out_item_t          out_item;

  // mirror of the mesh size registers
  logic [mxy_pkg::DIM_W-1:0]   mesh_w_sh = 5'd4;
  logic [mxy_pkg::DIM_W-1:0]   mesh_h_sh = 5'd4;

  mxy_pkg::out_item_t          route_q[$];   // route nodes still owed by the DUT
  int                          err_count = 0;
  int                          cycle_cnt = 0;
  int                          stall_run = 0;
  int                          free_run  = 0;

  mesh_xy_route_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Register value as the mesh sees it: 0 reads as 1, above 16 saturates.
  function automatic int eff_dim(logic [mxy_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > mxy_pkg::MAX_DIM_DEF) return mxy_pkg::MAX_DIM_DEF;
    return int'(v);
  endfunction

  // Append one node to the owed list.
  function automatic void owe_node(mxy_pkg::out_item_t n);
    route_q.insert(route_q.size(), n);
  endfunction

  // Expand one request into its XY node run and queue it. Column first,
  // then row; only the final node carries last.
  function automatic void plan_route(mxy_pkg::in_item_t req);
    int w;
    int h;
    int col;
    int row;
    int gc;
    int gr;
    mxy_pkg::out_item_t path[$];
    mxy_pkg::out_item_t step;
    w = eff_dim(mesh_w_sh);
    h = eff_dim(mesh_h_sh);
    if (int'(req.source_node) >= w * h || int'(req.target_node) >= w * h) begin
      step = '{node_id: req.source_node, last: 1'b1, error: 1'b1};
      owe_node(step);
      return;
    end
    col = int'(req.source_node) % w;
    row = int'(req.source_node) / w;
    gc  = int'(req.target_node) % w;
    gr  = int'(req.target_node) / w;
    step = '{node_id: req.source_node, last: 1'b0, error: 1'b0};
    path.insert(path.size(), step);
    while (col != gc) begin
      col = (gc > col) ? col + 1 : col - 1;
      step.node_id = mxy_pkg::NODE_W'(row * w + col);
      path.insert(path.size(), step);
    end
    while (row != gr) begin
      row = (gr > row) ? row + 1 : row - 1;
      step.node_id = mxy_pkg::NODE_W'(row * w + col);
      path.insert(path.size(), step);
    end
    path[path.size()-1].last = 1'b1;
    foreach (path[i]) owe_node(path[i]);
  endfunction

  function automatic void note_mismatch(string what, mxy_pkg::out_item_t want,
                                        mxy_pkg::out_item_t got);
    err_count++;
    if (err_count <= SHOW_MAX)
      $display("[%0t] %s: expected node=%0d last=%0b error=%0b, got node=%0d last=%0b error=%0b",
               $realtime, what, want.node_id, want.last, want.error,
               got.node_id, got.last, got.error);
  endfunction

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Mesh size register value, weighted toward the edges of the range.
  function automatic logic [mxy_pkg::DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return mxy_pkg::DIM_W'(mxy_pkg::MAX_DIM_DEF);
    if (r < 30) return '0;
    if (r < 40) return '1;
    if (r < 50) return mxy_pkg::DIM_W'(1);
    return mxy_pkg::DIM_W'($urandom_range(0, 31));
  endfunction

  // Mostly routes inside the mesh; some same-node and out-of-range requests.
  function automatic mxy_pkg::in_item_t random_request();
    int nodes;
    int r;
    mxy_pkg::in_item_t req;
    nodes = eff_dim(mesh_w_sh) * eff_dim(mesh_h_sh);
    r = $urandom_range(0, 99);
    req.source_node = mxy_pkg::NODE_W'($urandom_range(0, nodes - 1));
    req.target_node = mxy_pkg::NODE_W'($urandom_range(0, nodes - 1));
    if (r >= 75 && r < 82) begin
      req.target_node = req.source_node;
    end else if (r >= 82 && r < 92) begin
      if (r[0]) req.source_node = mxy_pkg::NODE_W'($urandom_range(0, 255));
      else req.target_node = mxy_pkg::NODE_W'($urandom_range(0, 255));
    end else if (r >= 92) begin
      req.source_node = mxy_pkg::NODE_W'($urandom_range(0, 255));
      req.target_node = mxy_pkg::NODE_W'($urandom_range(0, 255));
    end
    return req;
  endfunction

  // Present one request after an optional gap and hold it until accepted.
  // in_valid is left high so a following request can continue without a
  // dead cycle; callers lower it before going idle.
  task automatic send_request(mxy_pkg::in_item_t req, int gap, logic fixed,
                              mxy_pkg::out_item_t want);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fixed) owe_node(want);
    else plan_route(req);
  endtask

  // Mesh size changes only once every owed node has come out, plus a few
  // cycles for the walk to settle back to idle.
  task automatic write_reg(logic idx, logic [mxy_pkg::DIM_W-1:0] val);
    in_valid <= 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mxy_pkg::REG_MESH_WIDTH) mesh_w_sh = val;
    else mesh_h_sh = val;
  endtask

  // Result side: compare each delivered node with the oldest one owed.
  always @(posedge clk) begin
    mxy_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (route_q.size() == 0) begin
        note_mismatch("unexpected node", '0, out_item);
      end else begin
        want = route_q.pop_front();
        if (out_item.node_id !== want.node_id || out_item.last !== want.last ||
            out_item.error !== want.error)
          note_mismatch("node mismatch", want, out_item);
      end
    end
  end

  // Result side backpressure: runs without stalls, short bursts of stalls
  // and the odd long hold.
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
      out_stall <= 1'b1;
    end else if (free_run > 0) begin
      free_run  <= free_run - 1;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 5) stall_run <= $urandom_range(20, 60);
      else if (r < 45) stall_run <= $urandom_range(1, 3);
      else free_run <= $urandom_range(1, 20);
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    dir_row_t           row;
    mxy_pkg::in_item_t  req;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.src[0], row.dst[mxy_pkg::DIM_W-1:0]);
      end else begin
        req.source_node = row.src;
        req.target_node = row.dst;
        send_request(req, pick_gap(), row.fixed, row.want);
      end
    end

    // random phases, first one on the full 16x16 mesh so every node bit moves
    for (int p = 0; p < PHASES; p++) begin
      write_reg(mxy_pkg::REG_MESH_WIDTH,
                (p == 0) ? mxy_pkg::DIM_W'(mxy_pkg::MAX_DIM_DEF) : pick_dim());
      write_reg(mxy_pkg::REG_MESH_HEIGHT,
                (p == 0) ? mxy_pkg::DIM_W'(mxy_pkg::MAX_DIM_DEF) : pick_dim());
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_request(random_request(), pick_gap(), 1'b0, '0);
    end

    // drain and give stray nodes a chance to show up
    in_valid <= 1'b0;
    while (route_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
